>>> src/assert_macros.svh
// assert_macros.svh: assertion macros for the checker file, bf_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is high.
`define BF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define BF_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/bf_pkg.sv
// bf_pkg: types, operation codes and fixed port widths for the 3x3 box filter.
// No dependencies; imported by the top level, bf_lane, bf_merge and the checker.
package bf_pkg;

   localparam int CSR_W       = 11;   // image_size register width
   localparam int CHAN_PORT_W = 16;   // width of every channel port

   // Request operation codes.
   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } bf_op_type;

   // Window geometry of one request, shared by all channel lanes.
   typedef struct packed {
      logic [2:0] col_ok;   // left, centre, right column inside the image
      logic [2:0] row_ok;   // upper, middle, lower row inside the image
      logic [3:0] count;    // number of pixels in the clipped window
      logic       last;     // final output of the frame
   } bf_win_ctrl_type;

   // Stage loads driven by the pipeline control.
   typedef struct packed {
      logic load_b;
      logic load_c;
   } bf_lane_en_type;

endpackage

>>> src/box_filter_3x3_clipped.sv
// box_filter_3x3_clipped: streaming clipped 3x3 mean filter, top level.
// Depends on bf_pkg, bf_ram, bf_lane and bf_merge.
//
//   port group   direction  flow control     carries
//   req_*        in         valid / ready    operation, in_red/green/blue
//   rsp_*        out        valid / ready    out_red/green/blue, frame_last
//   csr_*        in         write enable     image_size, no read-back
//
// One request per clock when the response side keeps up; the response that a
// request produces passes the line store read, window sum, reciprocal
// multiply and correction into the output register, in that order.
// Reset clears control state and the window registers; the line stores are never cleared.
// A stalled response lets earlier stages keep filling until stage A blocks.
module box_filter_3x3_clipped
   import bf_pkg::*;
#(
   parameter int MAX_SIZE     = 1024,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [CHAN_PORT_W-1:0] req_in_red,
   input  logic [CHAN_PORT_W-1:0] req_in_green,
   input  logic [CHAN_PORT_W-1:0] req_in_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAN_PORT_W-1:0] rsp_out_red,
   output logic [CHAN_PORT_W-1:0] rsp_out_green,
   output logic [CHAN_PORT_W-1:0] rsp_out_blue,
   output logic                   rsp_frame_last,
   input  logic                   csr_wr_en,
   input  logic [CSR_W-1:0]       csr_wr_data
);

   localparam int   ADDR_W     = $clog2(MAX_SIZE);
   localparam int   CNT_W      = $clog2(MAX_SIZE + 2);
   localparam int   CH_W       = CHANNEL_BITS;
   localparam int   RESET_SIZE = (MAX_SIZE < 1024) ? MAX_SIZE : 1024;

   typedef logic [2:0][CH_W-1:0] pix_type;   // [channel]
   typedef logic [2:0][2:0][CH_W-1:0] col_type;   // [row][channel]

   // configuration and raster counters
   logic [CNT_W-1:0]  size_ff, size_in;
   logic [CNT_W-1:0]  size_p1;
   logic [31:0]       csr_ext;
   logic [31:0]       size_wr;
   logic [CNT_W-1:0]  ir_ff, ir_in;
   logic [ADDR_W-1:0] ic_ff, ic_in;
   logic [CNT_W-1:0]  ic_ext;
   logic [CNT_W-1:0]  orow;

   // request decode
   logic              in_frame;
   logic              accept;
   logic              enter_a;
   logic              is_e1, is_e2;
   logic [1:0]        ncols, nrows;
   bf_win_ctrl_type   ctrl_new;
   pix_type           pix_new;

   // stage A: line store data arrives
   logic              va_ff, va_in;
   logic [ADDR_W-1:0] ic_a_ff;
   pix_type           pix_a_ff;
   bf_win_ctrl_type   ctrl_a_ff;
   logic              emit_a_ff;
   logic              byp_ff;
   pix_type           byp_up_ff, byp_mid_ff;
   logic [3*CH_W-1:0] up_rd, mid_rd;
   pix_type           up_inc, mid_inc;
   col_type           inc;
   col_type           win1_ff, win1_in;
   col_type           win2_ff, win2_in;

   // later stages
   logic              vb_ff, vb_in;
   logic              vc_ff, vc_in;
   logic              last_b_ff, last_c_ff;
   logic              adv_a, adv_b;
   logic              ready_b, ready_c, ready_d;
   bf_lane_en_type    lane_en;
   logic [2:0][2:0][2:0][CH_W-1:0] lane_win;   // [channel][column][row]
   logic [2:0][CH_W-1:0]           lane_q;

   // ---------------------------------------------------------------- control
   assign ready_c = !vc_ff || ready_d;
   assign ready_b = !vb_ff || ready_c;
   assign adv_b   = vb_ff && ready_c;
   assign adv_a   = va_ff && (!emit_a_ff || ready_b);

   assign req_ready = !va_ff || adv_a;
   assign accept    = req_valid && req_ready;
   assign in_frame  = ir_ff < size_ff;
   // drop a flush that arrives before the image is complete
   assign enter_a   = accept && !((req_operation == OP_FLUSH) && in_frame);

   assign lane_en.load_b = adv_a && emit_a_ff;
   assign lane_en.load_c = adv_b;

   always_comb begin
      va_in = va_ff;
      if (enter_a) begin
         va_in = 1'b1;
      end else if (adv_a) begin
         va_in = 1'b0;
      end
      vb_in = vb_ff;
      if (lane_en.load_b) begin
         vb_in = 1'b1;
      end else if (adv_b) begin
         vb_in = 1'b0;
      end
      vc_in = vc_ff;
      if (adv_b) begin
         vc_in = 1'b1;
      end else if (ready_d) begin
         vc_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   // ---------------------------------------------------------- configuration
   assign csr_ext = 32'(csr_wr_data);

   always_comb begin
      if (csr_ext == 32'd0) begin
         size_wr = 32'd1;
      end else if (csr_ext > 32'(MAX_SIZE)) begin
         size_wr = 32'(MAX_SIZE);
      end else begin
         size_wr = csr_ext;
      end
   end

   assign size_in = csr_wr_en ? CNT_W'(size_wr) : size_ff;
   assign size_p1 = size_ff + CNT_W'(1);

   // ------------------------------------------------------- raster position
   assign ic_ext = CNT_W'(ic_ff);

   always_comb begin
      ir_in = ir_ff;
      ic_in = ic_ff;
      if (csr_wr_en) begin
         ir_in = '0;
         ic_in = '0;
      end else if (enter_a) begin
         if (ir_ff == size_p1) begin
            ir_in = '0;
            ic_in = '0;
         end else if (ic_ext + CNT_W'(1) == size_ff) begin
            ic_in = '0;
            ir_in = ir_ff + CNT_W'(1);
         end else begin
            ic_in = ic_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CNT_W'(RESET_SIZE);
         ir_ff   <= '0;
         ic_ff   <= '0;
      end else begin
         size_ff <= size_in;
         ir_ff   <= ir_in;
         ic_ff   <= ic_in;
      end
   end

   // Window placement: mid-row outputs lag one column, row starts emit the
   // right-hand pixel of the row before.
   assign is_e1 = (ic_ff != '0) && (ir_ff != '0);
   assign is_e2 = (ic_ff == '0) && (ir_ff >= CNT_W'(2));
   assign orow  = is_e1 ? ir_ff - CNT_W'(1) : ir_ff - CNT_W'(2);

   always_comb begin
      ctrl_new.col_ok[0] = is_e1 ? (ic_ext >= CNT_W'(2)) : (size_ff >= CNT_W'(2));
      ctrl_new.col_ok[1] = 1'b1;
      ctrl_new.col_ok[2] = is_e1;
      ctrl_new.row_ok[0] = orow != '0;
      ctrl_new.row_ok[1] = 1'b1;
      ctrl_new.row_ok[2] = (orow + CNT_W'(1)) < size_ff;
      ncols = 2'd1 + 2'(ctrl_new.col_ok[0]) + 2'(ctrl_new.col_ok[2]);
      nrows = 2'd1 + 2'(ctrl_new.row_ok[0]) + 2'(ctrl_new.row_ok[2]);
      ctrl_new.count = 4'(ncols) * 4'(nrows);
      ctrl_new.last  = ir_ff == size_p1;
   end

   always_comb begin
      pix_new = '0;
      if (in_frame) begin
         pix_new[0] = req_in_red[CH_W-1:0];
         pix_new[1] = req_in_green[CH_W-1:0];
         pix_new[2] = req_in_blue[CH_W-1:0];
      end
   end

   // ---------------------------------------------------------------- stage A
   always_ff @(posedge clock) begin
      if (enter_a) begin
         ic_a_ff    <= ic_ff;
         pix_a_ff   <= pix_new;
         ctrl_a_ff  <= ctrl_new;
         emit_a_ff  <= is_e1 || is_e2;
         // same address written this cycle: the RAM returns the old entry
         byp_ff     <= adv_a && (ic_a_ff == ic_ff);
         byp_up_ff  <= mid_inc;
         byp_mid_ff <= pix_a_ff;
      end
   end

   bf_ram #(
      .WIDTH (3 * CH_W),
      .DEPTH (MAX_SIZE)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (adv_a),
      .wr_addr (ic_a_ff),
      .wr_data (mid_inc),
      .rd_en   (enter_a),
      .rd_addr (ic_ff),
      .rd_data (up_rd)
   );

   bf_ram #(
      .WIDTH (3 * CH_W),
      .DEPTH (MAX_SIZE)
   ) u_middle_ram (
      .clock   (clock),
      .wr_en   (adv_a),
      .wr_addr (ic_a_ff),
      .wr_data (pix_a_ff),
      .rd_en   (enter_a),
      .rd_addr (ic_ff),
      .rd_data (mid_rd)
   );

   assign up_inc  = byp_ff ? byp_up_ff  : pix_type'(up_rd);
   assign mid_inc = byp_ff ? byp_mid_ff : pix_type'(mid_rd);

   always_comb begin
      inc[0] = up_inc;
      inc[1] = mid_inc;
      inc[2] = pix_a_ff;
   end

   always_comb begin
      win1_in = win1_ff;
      win2_in = win2_ff;
      if (csr_wr_en) begin
         win1_in = '0;
         win2_in = '0;
      end else if (adv_a) begin
         if (ctrl_a_ff.last) begin
            win1_in = '0;
            win2_in = '0;
         end else begin
            win1_in = win2_ff;
            win2_in = inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win1_ff <= '0;
         win2_ff <= '0;
      end else begin
         win1_ff <= win1_in;
         win2_ff <= win2_in;
      end
   end

   // ------------------------------------------------------------------ lanes
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < 3; r++) begin
            lane_win[ch][0][r] = win1_ff[r][ch];
            lane_win[ch][1][r] = win2_ff[r][ch];
            lane_win[ch][2][r] = inc[r][ch];
         end
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      bf_lane #(
         .CHANNEL_BITS (CH_W)
      ) u_lane (
         .clock (clock),
         .en    (lane_en),
         .ctrl  (ctrl_a_ff),
         .win   (lane_win[ch]),
         .quot  (lane_q[ch])
      );
   end

   always_ff @(posedge clock) begin
      if (lane_en.load_b) begin
         last_b_ff <= ctrl_a_ff.last;
      end
      if (lane_en.load_c) begin
         last_c_ff <= last_b_ff;
      end
   end

   // ------------------------------------------------------------------ merge
   bf_merge #(
      .CHANNEL_BITS (CH_W)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (vc_ff),
      .in_ready       (ready_d),
      .lane_q         (lane_q),
      .in_last        (last_c_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

>>> src/bf_ram.sv
// bf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; read-first when both ports hit the same address.
module bf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bf_lane.sv
// bf_lane: one colour channel; sums the clipped window and divides by its size.
// Depends on bf_pkg for the window control and stage load structs.
module bf_lane
   import bf_pkg::*;
#(
   parameter int CHANNEL_BITS = 16
) (
   input  logic                                 clock,
   input  bf_lane_en_type                       en,
   input  bf_win_ctrl_type                      ctrl,
   input  logic [2:0][2:0][CHANNEL_BITS-1:0]    win,    // [column][row]
   output logic [CHANNEL_BITS-1:0]              quot
);

   localparam int SUM_W  = CHANNEL_BITS + 4;
   localparam int PROD_W = 2 * SUM_W + 1;
   localparam int QD_W   = SUM_W + 4;

   // Truncated reciprocals; the quotient estimate is at most one short.
   localparam logic [SUM_W:0] RECIP_1 = (SUM_W + 1)'(1 << SUM_W);
   localparam logic [SUM_W:0] RECIP_2 = (SUM_W + 1)'((1 << SUM_W) / 2);
   localparam logic [SUM_W:0] RECIP_3 = (SUM_W + 1)'((1 << SUM_W) / 3);
   localparam logic [SUM_W:0] RECIP_4 = (SUM_W + 1)'((1 << SUM_W) / 4);
   localparam logic [SUM_W:0] RECIP_6 = (SUM_W + 1)'((1 << SUM_W) / 6);
   localparam logic [SUM_W:0] RECIP_9 = (SUM_W + 1)'((1 << SUM_W) / 9);

   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  sum_b_ff;
   logic [3:0]        cnt_b_ff;
   logic [SUM_W:0]    recip;
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  q0_c_ff;
   logic [SUM_W-1:0]  sum_c_ff;
   logic [3:0]        cnt_c_ff;
   logic [QD_W-1:0]   qd;
   logic [SUM_W-1:0]  rem;
   logic [SUM_W-1:0]  quot_full;

   always_comb begin
      sum_in = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            if (ctrl.col_ok[c] && ctrl.row_ok[r]) begin
               sum_in = sum_in + SUM_W'(win[c][r]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.load_b) begin
         sum_b_ff <= sum_in;
         cnt_b_ff <= ctrl.count;
      end
   end

   always_comb begin
      case (cnt_b_ff)
         4'd2:    recip = RECIP_2;
         4'd3:    recip = RECIP_3;
         4'd4:    recip = RECIP_4;
         4'd6:    recip = RECIP_6;
         4'd9:    recip = RECIP_9;
         default: recip = RECIP_1;
      endcase
   end

   assign prod = PROD_W'(sum_b_ff) * PROD_W'(recip);

   always_ff @(posedge clock) begin
      if (en.load_c) begin
         q0_c_ff  <= prod[2*SUM_W-1:SUM_W];
         sum_c_ff <= sum_b_ff;
         cnt_c_ff <= cnt_b_ff;
      end
   end

   // Bump the estimate when the remainder still holds a whole divisor.
   assign qd        = QD_W'(q0_c_ff) * QD_W'(cnt_c_ff);
   assign rem       = sum_c_ff - qd[SUM_W-1:0];
   assign quot_full = (rem >= SUM_W'(cnt_c_ff)) ? q0_c_ff + SUM_W'(1) : q0_c_ff;
   assign quot      = quot_full[CHANNEL_BITS-1:0];

endmodule

>>> src/bf_merge.sv
// bf_merge: joins the three lane results into one response and holds it.
// Depends on bf_pkg for the channel port width.
module bf_merge
   import bf_pkg::*;
#(
   parameter int CHANNEL_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [2:0][CHANNEL_BITS-1:0]     lane_q,
   input  logic                             in_last,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [CHAN_PORT_W-1:0]           rsp_out_red,
   output logic [CHAN_PORT_W-1:0]           rsp_out_green,
   output logic [CHAN_PORT_W-1:0]           rsp_out_blue,
   output logic                             rsp_frame_last
);

   logic                   valid_ff, valid_in;
   logic                   load;
   logic [CHAN_PORT_W-1:0] red_ff, green_ff, blue_ff;
   logic                   last_ff;

   assign in_ready = !valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff   <= CHAN_PORT_W'(lane_q[0]);
         green_ff <= CHAN_PORT_W'(lane_q[1]);
         blue_ff  <= CHAN_PORT_W'(lane_q[2]);
         last_ff  <= in_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_red    = red_ff;
   assign rsp_out_green  = green_ff;
   assign rsp_out_blue   = blue_ff;
   assign rsp_frame_last = last_ff;

endmodule

>>> src/bf_checker.sv
// bf_checker: port-level checks on the box filter's response side.
// Depends on bf_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module bf_checker
   import bf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [CHAN_PORT_W-1:0] rsp_out_red,
   input logic [CHAN_PORT_W-1:0] rsp_out_green,
   input logic [CHAN_PORT_W-1:0] rsp_out_blue,
   input logic                   rsp_frame_last
);

   // hold a stalled response
   `BF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_red) && $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_frame_last), "stalled response changed")

   `BF_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

   // with the output register empty nothing downstream can block a request
   `BF_ASSERT(a_ready_when_drained, clock, reset, !rsp_valid |-> req_ready, "request refused with empty output")

endmodule

bind box_filter_3x3_clipped bf_checker u_bf_checker (.*);
